/* src/adg_pkg.sv */
`default_nettype none

package adg_pkg;

  localparam int unsigned TableDepth  = 360;
  localparam int unsigned CoordWidth  = 32;
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned ExpSteps    = 7;

  localparam int unsigned XW = CoordWidth + 3;
  localparam int unsigned ZW = 26;
  localparam int unsigned AW = 17;

  localparam logic [AW-1:0]        Deg360Q8  = 17'd92160;
  localparam logic signed [ZW-1:0] Deg180Q16 = 26'sd11796480;
  localparam logic signed [ZW-1:0] Deg360Q16 = 26'sd23592960;
  localparam logic [22:0]          ExpScale  = 23'd2786635;
  localparam logic [31:0]          OneQ16    = 32'h0001_0000;

  typedef enum logic [1:0] {
    CfgPatternMode = 2'd0,
    CfgLowerAngle  = 2'd1,
    CfgUpperAngle  = 2'd2,
    CfgSectorGain  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        vld;
    logic        wr;
    logic        byp;
    logic [31:0] val;
    logic [8:0]  widx;
    logic [15:0] wdat;
  } item_ctl_t;

  function automatic logic signed [ZW-1:0] atan_deg(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 26'sd2949120;
      1:  r = 26'sd1740967;
      2:  r = 26'sd919879;
      3:  r = 26'sd466945;
      4:  r = 26'sd234379;
      5:  r = 26'sd117304;
      6:  r = 26'sd58666;
      7:  r = 26'sd29335;
      8:  r = 26'sd14668;
      9:  r = 26'sd7334;
      10: r = 26'sd3667;
      11: r = 26'sd1833;
      12: r = 26'sd917;
      13: r = 26'sd458;
      14: r = 26'sd229;
      15: r = 26'sd115;
      16: r = 26'sd57;
      17: r = 26'sd29;
      18: r = 26'sd14;
      19: r = 26'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] exp2_coef(input int unsigned k);
    logic [31:0] r;
    case (k)
      0: r = 32'd1073741824;
      1: r = 32'd744261118;
      2: r = 32'd257941248;
      3: r = 32'd59597083;
      4: r = 32'd10327387;
      5: r = 32'd1431680;
      6: r = 32'd165394;
      7: r = 32'd16378;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/antenna_direction_gain_top.sv */
`default_nettype none

// Channel   Handshake                  Payload
// request   in_valid_i / in_ready_o    kind, dir_x/y/z, entry_index, entry_db
// result    out_valid_o / out_ready_i  linear_gain
// config    cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// One request per cycle while no held result stalls the pipeline.
// The pipeline holds the 20 CORDIC stages and the 7 Horner multiply stages.
// Table writes land when they pass the table stage, in request order.
// A held result stalls the whole pipeline; reset empties it, the table is not cleared.

module antenna_direction_gain_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                kind_i,
  input  wire logic signed [31:0]  dir_x_i,
  input  wire logic signed [31:0]  dir_y_i,
  input  wire logic signed [31:0]  dir_z_i,
  input  wire logic [8:0]          entry_index_i,
  input  wire logic signed [15:0]  entry_db_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [31:0]              linear_gain_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [31:0]         cfg_wdata_i
);
  import adg_pkg::*;

  logic        pattern_mode_q;
  logic [8:0]  lower_angle_q, upper_angle_q;
  logic [31:0] sector_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_mode_q <= 1'b0;
      lower_angle_q  <= '0;
      upper_angle_q  <= '0;
      sector_gain_q  <= OneQ16;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPatternMode: pattern_mode_q <= cfg_wdata_i[0];
        CfgLowerAngle:  lower_angle_q  <= cfg_wdata_i[8:0];
        CfgUpperAngle:  upper_angle_q  <= cfg_wdata_i[8:0];
        CfgSectorGain:  sector_gain_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic        out_valid_q;
  logic [31:0] linear_gain_q;
  logic        adv;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // input stage: zero test, fold left half-plane
  logic signed [33:0] in_x, in_y;
  logic               in_neg;
  item_ctl_t          in_ctl;

  always_comb begin
    in_neg = dir_x_i < 0;
    in_x   = in_neg ? -34'(dir_x_i) : 34'(dir_x_i);
    in_y   = in_neg ? -34'(dir_y_i) : 34'(dir_y_i);
    in_ctl.vld  = in_valid_i;
    in_ctl.wr   = kind_i;
    in_ctl.byp  = (dir_x_i == 0) && (dir_y_i == 0) && (dir_z_i == 0);
    in_ctl.val  = OneQ16;
    in_ctl.widx = entry_index_i;
    in_ctl.wdat = entry_db_i;
  end

  logic signed [33:0] a_x_q, a_y_q;
  logic               a_neg_q, a_xy0_q;
  item_ctl_t          a_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctl_q <= '0;
    end else if (adv) begin
      a_ctl_q <= in_ctl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_x_q   <= in_x;
      a_y_q   <= in_y;
      a_neg_q <= in_neg;
      a_xy0_q <= (dir_x_i == 0) && (dir_y_i == 0);
    end
  end

  // normalize stage
  logic [31:0] nm_mag;
  logic [4:0]  nm_msb, nm_sh;
  logic signed [33:0] nm_ay;

  always_comb begin
    nm_ay  = a_y_q < 0 ? -a_y_q : a_y_q;
    nm_mag = a_x_q[31:0] | nm_ay[31:0];
    nm_msb = '0;
    for (int i = 0; i < 30; i++) begin
      if (nm_mag[i]) nm_msb = 5'(i);
    end
    nm_sh = (nm_mag[31] || nm_mag[30]) ? 5'd0 : 5'd30 - nm_msb;
  end

  logic signed [XW-1:0] c_x_q [CordicSteps+1];
  logic signed [XW-1:0] c_y_q [CordicSteps+1];
  logic signed [ZW-1:0] c_z_q [CordicSteps+1];
  logic                 c_xy0_q [CordicSteps+1];
  item_ctl_t            c_ctl_q [CordicSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_ctl_q[0] <= '0;
    end else if (adv) begin
      c_ctl_q[0] <= a_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_x_q[0]   <= XW'(a_x_q) <<< nm_sh;
      c_y_q[0]   <= XW'(a_y_q) <<< nm_sh;
      c_z_q[0]   <= a_neg_q ? Deg180Q16 : '0;
      c_xy0_q[0] <= a_xy0_q;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    logic signed [XW-1:0] dx, dy;
    assign dx = c_y_q[i] >>> i;
    assign dy = c_x_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_ctl_q[i+1] <= '0;
      end else if (adv) begin
        c_ctl_q[i+1] <= c_ctl_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (c_y_q[i] > 0) begin
          c_x_q[i+1] <= c_x_q[i] + dx;
          c_y_q[i+1] <= c_y_q[i] - dy;
          c_z_q[i+1] <= c_z_q[i] + atan_deg(i);
        end else begin
          c_x_q[i+1] <= c_x_q[i] - dx;
          c_y_q[i+1] <= c_y_q[i] + dy;
          c_z_q[i+1] <= c_z_q[i] - atan_deg(i);
        end
        c_xy0_q[i+1] <= c_xy0_q[i];
      end
    end
  end

  // angle stage: wrap and round to Q9.8
  logic signed [ZW-1:0] an_z, an_r;
  logic [AW-1:0]        an_q, an_ang;

  always_comb begin
    an_z   = c_z_q[CordicSteps] < 0 ? c_z_q[CordicSteps] + Deg360Q16 : c_z_q[CordicSteps];
    an_r   = an_z + ZW'(128);
    an_q   = an_r[AW+7:8];
    an_ang = (an_q >= Deg360Q8) ? an_q - Deg360Q8 : an_q;
    if (c_xy0_q[CordicSteps]) an_ang = '0;
  end

  logic [AW-1:0] g_ang_q;
  item_ctl_t     g_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_ctl_q <= '0;
    end else if (adv) begin
      g_ctl_q <= c_ctl_q[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_ang_q <= an_ang;
    end
  end

  // table stage: sector decision, table addresses, table write
  logic [AW-1:0]        sc_lo, sc_hi;
  logic                 sc_in_arc;
  logic signed [AW+1:0] sc_diff;
  logic [8:0]           sc_a0, sc_a1;
  item_ctl_t            sc_ctl;

  always_comb begin
    sc_lo = {lower_angle_q, 8'd0};
    sc_hi = {upper_angle_q, 8'd0};
    if (sc_hi > sc_lo) begin
      sc_in_arc = (g_ang_q >= sc_lo) && (g_ang_q <= sc_hi);
    end else if (sc_hi < sc_lo) begin
      sc_in_arc = (g_ang_q >= sc_lo) || (g_ang_q <= sc_hi);
    end else begin
      sc_in_arc = 1'b1;
    end
    sc_diff = $signed({2'b00, g_ang_q}) - $signed({2'b00, sc_lo});
    if (sc_diff < 0) sc_diff = sc_diff + $signed({2'b00, Deg360Q8});
    if (sc_diff < 0) sc_diff = sc_diff + $signed({2'b00, Deg360Q8});
    sc_a0 = sc_diff[16:8];
    sc_a1 = (sc_a0 == 9'(TableDepth - 1)) ? '0 : sc_a0 + 9'd1;
    sc_ctl = g_ctl_q;
    if (!g_ctl_q.byp && !pattern_mode_q) begin
      sc_ctl.byp = 1'b1;
      sc_ctl.val = sc_in_arc ? sector_gain_q : '0;
    end
  end

  logic [15:0] tbl_mem [TableDepth];
  logic [15:0] m_d0_q, m_d1_q;
  item_ctl_t   m_ctl_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (g_ctl_q.vld && g_ctl_q.wr && (g_ctl_q.widx < 9'(TableDepth))) begin
        tbl_mem[g_ctl_q.widx] <= g_ctl_q.wdat;
      end
      m_d0_q <= tbl_mem[sc_a0];
      m_d1_q <= tbl_mem[sc_a1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ctl_q <= '0;
    end else if (adv) begin
      m_ctl_q <= sc_ctl;
    end
  end

  // exponent stage: dB sum times log2(10)/10
  logic signed [16:0] ex_sum;
  logic signed [39:0] ex_t;

  always_comb begin
    ex_sum = 17'($signed(m_d0_q)) + 17'($signed(m_d1_q));
    ex_t   = 40'(ex_sum) * 40'($signed({1'b0, ExpScale}));
  end

  logic signed [39:0] e_t_q;
  item_ctl_t          e_ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_ctl_q <= '0;
    end else if (adv) begin
      e_ctl_q <= m_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_t_q <= ex_t;
    end
  end

  // Horner evaluation of 2^f, one coefficient per stage
  logic signed [7:0] h_n_q [ExpSteps+1];
  logic [29:0]       h_f_q [ExpSteps+1];
  logic [31:0]       h_p_q [ExpSteps+1];
  item_ctl_t         h_ctl_q [ExpSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_ctl_q[0] <= '0;
    end else if (adv) begin
      h_ctl_q[0] <= e_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_n_q[0] <= e_t_q[39:32];
      h_f_q[0] <= e_t_q[31:2];
      h_p_q[0] <= exp2_coef(ExpSteps);
    end
  end

  for (genvar j = 0; j < ExpSteps; j++) begin : g_horner
    logic [61:0] prod;
    assign prod = 62'(h_p_q[j]) * 62'(h_f_q[j]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        h_ctl_q[j+1] <= '0;
      end else if (adv) begin
        h_ctl_q[j+1] <= h_ctl_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        h_p_q[j+1] <= exp2_coef(ExpSteps - 1 - j) + prod[61:30];
        h_n_q[j+1] <= h_n_q[j];
        h_f_q[j+1] <= h_f_q[j];
      end
    end
  end

  // scale by 2^n, round, saturate
  logic signed [7:0] fn_n;
  logic [7:0]        fn_s;
  logic [33:0]       fn_up;
  logic [63:0]       fn_dn;
  logic [31:0]       fn_gain;
  item_ctl_t         fn_ctl;

  always_comb begin
    fn_ctl = h_ctl_q[ExpSteps];
    fn_n   = h_n_q[ExpSteps];
    fn_s   = 8'sd14 - fn_n;
    fn_up  = {2'b00, h_p_q[ExpSteps]} << fn_n[0];
    fn_dn  = '0;
    if (fn_n >= 8'sd16) begin
      fn_gain = '1;
    end else if (fn_n >= 8'sd14) begin
      fn_gain = (fn_up[33:32] != 2'b00) ? '1 : fn_up[31:0];
    end else if (fn_s > 8'd62) begin
      fn_gain = '0;
    end else begin
      fn_dn   = ({32'd0, h_p_q[ExpSteps]} + (64'd1 << (fn_s - 8'd1))) >> fn_s;
      fn_gain = fn_dn[31:0];
    end
    if (fn_ctl.byp) fn_gain = fn_ctl.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fn_ctl.vld && !fn_ctl.wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      linear_gain_q <= fn_gain;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign linear_gain_o = linear_gain_q;

  a_stall_holds_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(h_ctl_q[ExpSteps]) && $stable(linear_gain_q))
    else $error("pipeline tail moved during stall");

  a_table_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (g_ctl_q.vld && !g_ctl_q.wr) |-> (sc_a0 < 9'(TableDepth)) && (sc_a1 < 9'(TableDepth)))
    else $error("table address out of range");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && fn_ctl.vld && fn_ctl.wr) |=> !out_valid_q)
    else $error("table write produced a result");

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;
  import adg_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               kind_i = 1'b0;
  logic signed [31:0] dir_x_i = '0;
  logic signed [31:0] dir_y_i = '0;
  logic signed [31:0] dir_z_i = '0;
  logic [8:0]         entry_index_i = '0;
  logic signed [15:0] entry_db_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [31:0]        linear_gain_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = '0;
  logic [31:0]        cfg_wdata_i = '0;

  logic [31:0] gain_q[$];
  bit          failed = 1'b0;
  bit          no_gaps = 1'b0;

  logic        mode_r;
  logic [8:0]  lower_r;
  logic [8:0]  upper_r;
  logic [31:0] sgain_r;
  logic [15:0] db_table[TableDepth];

  localparam longint AtanQ16[20] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };
  localparam longint unsigned PolyQ30[8] = '{
    1073741824, 744261118, 257941248, 59597083,
    10327387, 1431680, 165394, 16378
  };

  antenna_direction_gain_top i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint azimuth(longint x, longint y);
    longint z, dx, dy, q;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 180 * 65536;
    end
    while (((x < 0 ? -x : x) | (y < 0 ? -y : y)) < (64'sd1 <<< 30)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += AtanQ16[i];
      end else begin
        x -= dx; y += dy; z -= AtanQ16[i];
      end
    end
    if (z < 0) z += 360 * 65536;
    q = (z + 128) >>> 8;
    if (q >= 92160) q -= 92160;
    return q;
  endfunction

  function automatic logic [31:0] db_to_gain(longint dbsum);
    longint t, n;
    longint unsigned f, p, r;
    int s;
    t = dbsum * 2786635;
    n = t >>> 32;
    f = (longint'(t) & 64'hFFFF_FFFF) >> 2;
    p = PolyQ30[7];
    for (int k = 6; k >= 0; k--) p = PolyQ30[k] + ((p * f) >> 30);
    if (n >= 16) return 32'hFFFF_FFFF;
    if (n >= 14) begin
      r = p << (n - 14);
    end else begin
      s = int'(14 - n);
      if (s > 62) return 32'd0;
      r = (p + (64'd1 << (s - 1))) >> s;
    end
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    return r[31:0];
  endfunction

  function automatic void predict(logic k, logic signed [31:0] x, logic signed [31:0] y,
                                  logic signed [31:0] z, logic [8:0] idx, logic [15:0] db);
    longint ang, lo, hi, diff;
    int i0, i1;
    bit hit;
    if (k) begin
      if (idx < TableDepth) db_table[idx] = db;
      return;
    end
    if (x == 0 && y == 0 && z == 0) begin
      gain_q.push_back(OneQ16);
      return;
    end
    ang = azimuth(longint'(x), longint'(y));
    lo = longint'(lower_r) * 256;
    hi = longint'(upper_r) * 256;
    if (!mode_r) begin
      if (hi > lo) hit = ang >= lo && ang <= hi;
      else if (hi < lo) hit = ang >= lo || ang <= hi;
      else hit = 1'b1;
      gain_q.push_back(hit ? sgain_r : 32'd0);
    end else begin
      diff = ang - lo;
      while (diff < 0) diff += 92160;
      i0 = int'((diff >> 8) % TableDepth);
      i1 = int'((i0 + 1) % TableDepth);
      gain_q.push_back(db_to_gain(longint'($signed(db_table[i0]))
                                  + longint'($signed(db_table[i1]))));
    end
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 6))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 40) - 20;
      3: v = '0;
      4: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: v = $signed($urandom) >>> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  always @(negedge clk_i) begin
    if (no_gaps) out_ready_i <= 1'b1;
    else if ($urandom_range(0, 99) < 3) out_ready_i <= 1'b0;
    else if (!out_ready_i && $urandom_range(0, 99) < 8) out_ready_i <= 1'b0;
    else out_ready_i <= $urandom_range(0, 99) < 80;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gain_q.size() == 0) begin
        $error("linear_gain: unexpected result %h", linear_gain_o);
        failed = 1'b1;
      end else begin
        if (linear_gain_o !== gain_q[0]) begin
          $error("linear_gain expected %h actual %h", gain_q[0], linear_gain_o);
          failed = 1'b1;
        end
        void'(gain_q.pop_front());
      end
    end
  end

  task automatic send(logic k, logic signed [31:0] x, logic signed [31:0] y,
                      logic signed [31:0] z, logic [8:0] idx, logic [15:0] db);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    kind_i = k;
    dir_x_i = x;
    dir_y_i = y;
    dir_z_i = z;
    entry_index_i = idx;
    entry_db_i = db;
    do @(posedge clk_i); while (!in_ready_o);
    predict(k, x, y, z, idx, db);
    @(negedge clk_i);
  endtask

  task automatic query(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
    send(1'b0, x, y, z, '0, 16'($urandom));
  endtask

  task automatic table_write(logic [8:0] idx, logic [15:0] db);
    send(1'b1, $urandom, $urandom, $urandom, idx, db);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [31:0] val);
    in_valid_i = 1'b0;
    wait (gain_q.size() == 0);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgPatternMode: mode_r = val[0];
      CfgLowerAngle:  lower_r = val[8:0];
      CfgUpperAngle:  upper_r = val[8:0];
      default:        sgain_r = val;
    endcase
  endtask

  task automatic set_sector(logic [8:0] lo, logic [8:0] hi, logic [31:0] g);
    set_reg(CfgLowerAngle, 32'(lo));
    set_reg(CfgUpperAngle, 32'(hi));
    set_reg(CfgSectorGain, g);
  endtask

  task automatic test_sector_directed();
    query(0, 0, 0);
    query(0, 0, 5);
    query(0, 0, 32'h8000_0000);
    query(1, 0, 0);
    query(-1, 0, 0);
    query(0, 1, 0);
    query(0, -1, 0);
    query(32'h7FFF_FFFF, -1, 0);
    set_sector(9'd90, 9'd180, 32'hFFFF_FFFF);
    query(0, 1, 0);
    query(-1, 0, 0);
    query(1, 1, 0);
    query(32'h8000_0000, 32'h8000_0000, 0);
    set_sector(9'd300, 9'd45, 32'd0);
    query(1, 0, 0);
    query(1, -1, 0);
    query(0, -1, 0);
    set_sector(9'd400, 9'd511, 32'h1234_5678);
    query(32'h8000_0000, 32'h7FFF_FFFF, 1);
    query(-3, 0, 0);
  endtask

  task automatic test_sector_random();
    for (int ph = 0; ph < 5; ph++) begin
      no_gaps = ph == 2;
      set_sector(9'($urandom_range(0, ph == 4 ? 511 : 359)), 9'($urandom_range(0, 359)),
                 $urandom);
      repeat (35) query(rand_coord(), rand_coord(), rand_coord());
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_table_load();
    for (int i = 0; i < TableDepth; i++) table_write(9'(i), 16'($urandom));
    table_write(9'd10, 16'sh7FFF);
    table_write(9'd11, 16'sh7FFF);
    table_write(9'd20, 16'sh8000);
    table_write(9'd21, 16'sh8000);
    table_write(9'd360, 16'h0000);
    table_write(9'd511, 16'hFFFF);
  endtask

  task automatic test_pattern_directed();
    set_reg(CfgPatternMode, 32'd1);
    set_reg(CfgLowerAngle, 32'd350);
    query(1, 0, 0);
    query(0, 0, 0);
    set_reg(CfgLowerAngle, 32'd340);
    query(1, 0, 0);
    query(0, 0, -7);
    set_reg(CfgLowerAngle, 32'd511);
    query(-1, 0, 0);
    query(0, -1, 0);
    set_reg(CfgLowerAngle, 32'd0);
    query(-1, -1, 0);
  endtask

  task automatic test_pattern_random();
    int r;
    for (int ph = 0; ph < 5; ph++) begin
      no_gaps = ph == 1;
      set_reg(CfgLowerAngle, $urandom_range(0, ph == 3 ? 511 : 359));
      for (int n = 0; n < 35; n++) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          table_write(9'($urandom_range(0, 359)), 16'($urandom));
        end else if (r == 1) begin
          table_write(9'($urandom_range(0, 359)), 16'($urandom_range(0, 3000) - 1500));
        end else if (r == 2 && n % 8 == 0) begin
          table_write(9'($urandom_range(360, 511)), 16'($urandom));
        end else begin
          query(rand_coord(), rand_coord(), rand_coord());
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    mode_r = 1'b0;
    lower_r = '0;
    upper_r = '0;
    sgain_r = OneQ16;
    for (int i = 0; i < TableDepth; i++) db_table[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_sector_directed();
    test_sector_random();
    test_table_load();
    test_pattern_directed();
    test_pattern_random();
    set_reg(CfgPatternMode, 32'd0);
    set_sector(9'd0, 9'd359, 32'h0002_0000);
    repeat (20) query(rand_coord(), rand_coord(), rand_coord());
    in_valid_i = 1'b0;
    wait (gain_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (!failed) $display("antenna_direction_gain_top: match");
    else $display("antenna_direction_gain_top: mismatch");
    $finish;
  end

  initial begin
    #(20 * 600000);
    $display("antenna_direction_gain_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
src/adg_pkg.sv
src/antenna_direction_gain_top.sv
test/testbench.sv
